// ----- rtl/lfuct_pkg.sv -----
// shared constants and types for the lfu cache table
`timescale 1ns / 1ps
`default_nettype none

package lfuct_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CAP_W          = 5;
  localparam int KEY_W          = 32;
  localparam int DATA_W         = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  // status of one sweep over the table
  typedef struct packed {
    logic found;
    logic victim_any;
    logic free_any;
  } search_flags_t;

endpackage

`default_nettype wire

// ----- rtl/lfuct_search.sv -----
// sweep accumulator: key match, lfu victim with recency tiebreak, free slot, fill
`timescale 1ns / 1ps
`default_nettype none

module lfuct_search #(
  parameter int  ENTRIES    = lfuct_pkg::ENTRIES_DEF,
  parameter int  COUNT_BITS = lfuct_pkg::COUNT_BITS_DEF,
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              clear,
  input  wire logic                              step,
  input  wire logic [IDX_W-1:0]                  idx,
  input  wire logic                              ent_valid,
  input  wire logic [lfuct_pkg::KEY_W-1:0]       ent_key,
  input  wire logic [lfuct_pkg::DATA_W-1:0]      ent_data,
  input  wire logic [COUNT_BITS-1:0]             ent_cnt,
  input  wire logic [IDX_W-1:0]                  ent_rank,
  input  wire logic [lfuct_pkg::KEY_W-1:0]       lookup_key,
  output lfuct_pkg::search_flags_t               flags,
  output logic      [IDX_W-1:0]                  found_idx,
  output logic      [lfuct_pkg::DATA_W-1:0]      found_data,
  output logic      [COUNT_BITS-1:0]             found_cnt,
  output logic      [IDX_W-1:0]                  found_rank,
  output logic      [IDX_W-1:0]                  vic_idx,
  output logic      [IDX_W-1:0]                  vic_rank,
  output logic      [IDX_W-1:0]                  free_idx,
  output logic      [IDX_W:0]                    used
);

  logic [COUNT_BITS-1:0] vic_cnt;
  logic                  take_victim;

  // strict compares keep the lowest index among equal candidates
  assign take_victim = !flags.victim_any || (ent_cnt < vic_cnt) ||
                       ((ent_cnt == vic_cnt) && (ent_rank > vic_rank));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flags <= '0;
      used  <= '0;
    end else if (step) begin
      if (ent_valid) begin
        used <= used + 1'b1;
        if ((ent_key == lookup_key) && !flags.found) begin
          flags.found <= 1'b1;
          found_idx   <= idx;
          found_data  <= ent_data;
          found_cnt   <= ent_cnt;
          found_rank  <= ent_rank;
        end
        if (take_victim) begin
          flags.victim_any <= 1'b1;
          vic_idx          <= idx;
          vic_cnt          <= ent_cnt;
          vic_rank         <= ent_rank;
        end
      end else if (!flags.free_any) begin
        flags.free_any <= 1'b1;
        free_idx       <= idx;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lfu_cache_table_core.sv -----
// top level of the lfu cache table: command port, entry memories and sweep control
`timescale 1ns / 1ps
`default_nettype none

// Key-value table with least-frequently-used replacement and a least-recently-used
// tiebreak. A command is taken when start is high and busy is low; its result shows
// on hit, read_value and evicted for exactly one cycle with done high, and the
// receiver cannot hold it off. Each command sweeps the entry memories one entry per
// cycle and then writes back, and the next command may be taken in the cycle done
// is high; with capacity 0 the result comes in the cycle after the transfer. The
// sweep rate is set by the single read port of the entry and rank memories.
// Capacity is written through cfg_wr_en / cfg_wr_data; the user keeps to writing
// it while no command is in flight, which the block itself does not enforce.

module lfu_cache_table_core #(
  parameter int ENTRIES    = lfuct_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfuct_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // capacity register
  input  wire logic                                   cfg_wr_en,
  input  wire logic        [lfuct_pkg::CAP_W-1:0]     cfg_wr_data,
  // command side
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic                                   command,
  input  wire logic signed [lfuct_pkg::KEY_W-1:0]     key,
  input  wire logic signed [lfuct_pkg::DATA_W-1:0]    value,
  // result side
  output logic                                        done,
  output logic                                        hit,
  output logic signed      [lfuct_pkg::DATA_W-1:0]    read_value,
  output logic                                        evicted
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int CMP_W = (lfuct_pkg::CAP_W > CNT_W) ? lfuct_pkg::CAP_W : CNT_W;

  typedef struct packed {
    logic [lfuct_pkg::KEY_W-1:0]  key;
    logic [lfuct_pkg::DATA_W-1:0] data;
    logic [COUNT_BITS-1:0]        cnt;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  state_t state;

  // capacity register and per-command copies
  logic [lfuct_pkg::CAP_W-1:0]  capacity;
  logic [CMP_W-1:0]             cap_wide;
  logic [CNT_W-1:0]             cap_eff;
  logic [CNT_W-1:0]             cap_q;
  lfuct_pkg::cmd_t              cmd_q;
  logic [lfuct_pkg::KEY_W-1:0]  key_q;
  logic [lfuct_pkg::DATA_W-1:0] value_q;

  // valid bits live in flops so reset clears them at once
  logic [ENTRIES-1:0] entry_valid;

  // entry memory (key, data, use count) and rank memory
  entry_t           entry_mem [ENTRIES];
  logic [IDX_W-1:0] rank_mem  [ENTRIES];
  entry_t           ent_q;
  logic [IDX_W-1:0] rank_q;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr;
  entry_t           ent_wdata;
  logic             rank_we;
  logic [IDX_W-1:0] rank_waddr;
  logic [IDX_W-1:0] rank_wdata;

  // sweep counters: iss is the next address to read, chk the entry whose data is out
  logic [CNT_W-1:0] iss;
  logic             iss_done;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  logic             accept;
  logic             cap_zero;

  // rank aging left over from the previous command, applied as the sweep passes
  logic             pend;
  logic [IDX_W-1:0] pend_slot;
  logic [CNT_W-1:0] pend_thresh;
  logic [IDX_W-1:0] adj_rank;
  logic             chk_ent_valid;

  // sweep results
  lfuct_pkg::search_flags_t     flags;
  logic [IDX_W-1:0]             found_idx;
  logic [lfuct_pkg::DATA_W-1:0] found_data;
  logic [COUNT_BITS-1:0]        found_cnt;
  logic [IDX_W-1:0]             found_rank;
  logic [IDX_W-1:0]             vic_idx;
  logic [IDX_W-1:0]             vic_rank;
  logic [IDX_W-1:0]             free_idx;
  logic [CNT_W-1:0]             used;

  // write-phase decisions
  logic                  is_put;
  logic                  do_evict;
  logic                  do_fill;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [CNT_W-1:0]      thresh_next;

  // capacity above the table size acts as the table size
  assign cap_wide = CMP_W'(capacity);
  assign cap_eff  = (cap_wide > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cap_wide);
  assign cap_zero = (cap_eff == '0);

  assign busy     = (state != ST_IDLE);
  assign accept   = start && (state == ST_IDLE);
  assign iss_done = (iss == CNT_W'(ENTRIES));

  // address 0 goes out with the transfer, the rest one a cycle during the sweep
  assign rd_en   = (accept && !cap_zero) || ((state == ST_SCAN) && !iss_done);
  assign rd_addr = (state == ST_IDLE) ? '0 : iss[IDX_W-1:0];

  // pending aging: valid entries other than the touched slot and younger than it
  assign chk_ent_valid = entry_valid[chk_idx];
  assign adj_rank = rank_q + IDX_W'(pend && (chk_idx != pend_slot) &&
                                    ({1'b0, rank_q} < pend_thresh));

  lfuct_search #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_search (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .step       (chk_vld),
    .idx        (chk_idx),
    .ent_valid  (chk_ent_valid),
    .ent_key    (ent_q.key),
    .ent_data   (ent_q.data),
    .ent_cnt    (ent_q.cnt),
    .ent_rank   (adj_rank),
    .lookup_key (key_q),
    .flags      (flags),
    .found_idx  (found_idx),
    .found_data (found_data),
    .found_cnt  (found_cnt),
    .found_rank (found_rank),
    .vic_idx    (vic_idx),
    .vic_rank   (vic_rank),
    .free_idx   (free_idx),
    .used       (used)
  );

  // an absent key evicts when the table is at or above capacity, else takes a free slot
  assign is_put   = (cmd_q == lfuct_pkg::CMD_PUT);
  assign do_evict = is_put && !flags.found && (used >= cap_q) && flags.victim_any;
  assign do_fill  = is_put && !flags.found && !do_evict && flags.free_any;

  // use count saturates at all ones
  assign cnt_inc = (found_cnt == {COUNT_BITS{1'b1}}) ? found_cnt
                                                     : found_cnt + COUNT_BITS'(1);

  always_comb begin
    ent_we         = (state == ST_WRITE) && (flags.found || do_evict || do_fill);
    ent_waddr      = flags.found ? found_idx : (do_evict ? vic_idx : free_idx);
    ent_wdata.key  = key_q;
    ent_wdata.data = (flags.found && !is_put) ? found_data : value_q;
    ent_wdata.cnt  = flags.found ? cnt_inc : COUNT_BITS'(1);
    // a fill ages every other valid entry, a touch or an eviction only the younger ones
    if (flags.found) begin
      thresh_next = {1'b0, found_rank};
    end else if (do_evict) begin
      thresh_next = {1'b0, vic_rank};
    end else begin
      thresh_next = CNT_W'(ENTRIES);
    end
    // rank port: write-back of aged ranks during the sweep, rank 0 for the touched slot
    if (state == ST_WRITE) begin
      rank_we    = ent_we;
      rank_waddr = ent_waddr;
      rank_wdata = '0;
    end else begin
      rank_we    = chk_vld && chk_ent_valid;
      rank_waddr = chk_idx;
      rank_wdata = adj_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
    if (rd_en) begin
      ent_q <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    if (rd_en) begin
      rank_q <= rank_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfuct_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // command sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      chk_vld     <= 1'b0;
      pend        <= 1'b0;
      entry_valid <= '0;
      iss         <= '0;
    end else begin
      done    <= 1'b0;
      chk_vld <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= lfuct_pkg::cmd_t'(command);
            key_q   <= key;
            value_q <= value;
            cap_q   <= cap_eff;
            if (cap_zero) begin
              // disabled table: miss without touching anything
              done       <= 1'b1;
              hit        <= 1'b0;
              read_value <= lfuct_pkg::MISS_VALUE;
              evicted    <= 1'b0;
            end else begin
              state   <= ST_SCAN;
              iss     <= CNT_W'(1);
              chk_vld <= 1'b1;
              chk_idx <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (!iss_done) begin
            iss     <= iss + 1'b1;
            chk_vld <= 1'b1;
            chk_idx <= iss[IDX_W-1:0];
          end
          if (chk_vld && (chk_idx == IDX_W'(ENTRIES - 1))) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state       <= ST_IDLE;
          pend        <= ent_we;
          pend_slot   <= ent_waddr;
          pend_thresh <= thresh_next;
          if (do_fill) begin
            entry_valid[free_idx] <= 1'b1;
          end
          done       <= 1'b1;
          hit        <= flags.found;
          read_value <= (flags.found && !is_put) ? found_data : lfuct_pkg::MISS_VALUE;
          evicted    <= do_evict;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
